[design/assert_macros.svh]
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jfc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jfc assertion failed");

`endif

[design/jfc_pkg.sv]
package jfc_pkg;

  // Marker codes
  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_EOI    = 8'hD9;
  localparam logic [7:0] MARKER_SOS    = 8'hDA;
  localparam logic [7:0] MARKER_TEM    = 8'h01;
  localparam logic [7:0] MARKER_RST0   = 8'hD0;
  localparam logic [7:0] MARKER_RST7   = 8'hD7;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;

  // Segment limits and SOF0 field checks
  localparam logic [15:0] SEG_MIN_LEN   = 16'd2;
  localparam logic [15:0] SOF0_MIN_LEN  = 16'd17;
  localparam logic [15:0] POS_BODY_START = 16'd2;
  localparam logic [15:0] POS_NCOMP     = 16'd7;
  localparam logic [15:0] POS_SAMP0     = 16'd9;
  localparam logic [15:0] POS_SAMP1     = 16'd12;
  localparam logic [15:0] POS_SAMP2     = 16'd15;
  localparam logic [7:0]  NCOMP_444     = 8'd3;
  localparam logic [7:0]  SAMP_444      = 8'h11;

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_MARK,
    PH_FILL,
    PH_LENHI,
    PH_LENLO,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] byte_position;
    logic [15:0] segment_length;
    logic        frame_segment;
    logic        sampling_ok;
    logic        verdict;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:          PH_START0,
    byte_position:  16'd0,
    segment_length: 16'd0,
    frame_segment:  1'b0,
    sampling_ok:    1'b1,
    verdict:        1'b0
  };

endpackage

[design/jfc_in_if.sv]
interface jfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/jfc_out_if.sv]
interface jfc_out_if;
  logic valid;
  logic ready;
  logic is_444;

  modport source (output valid, output is_444, input ready);
  modport sink   (input valid, input is_444, output ready);
endinterface

[design/jfc_step.sv]
// Next-state function of the marker walker for one byte.
module jfc_step (
  input  jfc_pkg::parse_state_t cur,
  input  logic [7:0]            data_byte,
  output jfc_pkg::parse_state_t nxt
);

  logic [15:0] full_len;
  logic [15:0] pos_inc;
  logic        len_bad;
  logic        len_done;
  logic        body_done;
  logic        samp_fail;
  logic        samp_ok_upd;
  jfc_pkg::phase_t next_phase;

  assign full_len = {cur.segment_length[15:8], data_byte};
  assign pos_inc  = cur.byte_position + 16'd1;
  assign len_bad  = (full_len < jfc_pkg::SEG_MIN_LEN) ||
                    (cur.frame_segment && (full_len < jfc_pkg::SOF0_MIN_LEN));
  // only a two-byte segment ends on its length
  assign len_done  = (jfc_pkg::POS_BODY_START >= full_len);
  assign body_done = (pos_inc >= cur.segment_length);

  always_comb begin
    samp_fail = 1'b0;
    if (cur.frame_segment) begin
      if ((cur.byte_position == jfc_pkg::POS_NCOMP) && (data_byte != jfc_pkg::NCOMP_444)) begin
        samp_fail = 1'b1;
      end
      if (((cur.byte_position == jfc_pkg::POS_SAMP0) ||
           (cur.byte_position == jfc_pkg::POS_SAMP1) ||
           (cur.byte_position == jfc_pkg::POS_SAMP2)) &&
          (data_byte != jfc_pkg::SAMP_444)) begin
        samp_fail = 1'b1;
      end
    end
  end

  assign samp_ok_upd = cur.sampling_ok && !samp_fail;

  // next phase
  always_comb begin
    next_phase = cur.phase;
    case (cur.phase)
      jfc_pkg::PH_START0: begin
        next_phase = (data_byte == jfc_pkg::MARKER_PREFIX) ? jfc_pkg::PH_START1
                                                           : jfc_pkg::PH_DONE;
      end
      jfc_pkg::PH_START1: begin
        next_phase = (data_byte == jfc_pkg::MARKER_SOI) ? jfc_pkg::PH_MARK
                                                        : jfc_pkg::PH_DONE;
      end
      jfc_pkg::PH_MARK: begin
        next_phase = (data_byte == jfc_pkg::MARKER_PREFIX) ? jfc_pkg::PH_FILL
                                                           : jfc_pkg::PH_DONE;
      end
      jfc_pkg::PH_FILL: begin
        if (data_byte == jfc_pkg::MARKER_PREFIX) begin
          next_phase = jfc_pkg::PH_FILL;
        end else if (data_byte inside {jfc_pkg::MARKER_EOI, jfc_pkg::MARKER_SOS}) begin
          next_phase = jfc_pkg::PH_DONE;
        end else if (data_byte inside {jfc_pkg::MARKER_TEM,
                                       [jfc_pkg::MARKER_RST0:jfc_pkg::MARKER_RST7]}) begin
          next_phase = jfc_pkg::PH_MARK;
        end else begin
          next_phase = jfc_pkg::PH_LENHI;
        end
      end
      jfc_pkg::PH_LENHI: begin
        next_phase = jfc_pkg::PH_LENLO;
      end
      jfc_pkg::PH_LENLO: begin
        if (len_bad) begin
          next_phase = jfc_pkg::PH_DONE;
        end else if (len_done) begin
          next_phase = jfc_pkg::PH_MARK;
        end else begin
          next_phase = jfc_pkg::PH_BODY;
        end
      end
      jfc_pkg::PH_BODY: begin
        if (body_done) begin
          next_phase = cur.frame_segment ? jfc_pkg::PH_DONE : jfc_pkg::PH_MARK;
        end
      end
      default: begin
        next_phase = cur.phase;
      end
    endcase
  end

  // segment bookkeeping and verdict
  always_comb begin
    nxt.phase          = next_phase;
    nxt.byte_position  = cur.byte_position;
    nxt.segment_length = cur.segment_length;
    nxt.frame_segment  = cur.frame_segment;
    nxt.sampling_ok    = cur.sampling_ok;
    nxt.verdict        = cur.verdict;
    case (cur.phase)
      jfc_pkg::PH_START0, jfc_pkg::PH_START1, jfc_pkg::PH_MARK: begin
        if (data_byte != ((cur.phase == jfc_pkg::PH_START1) ? jfc_pkg::MARKER_SOI
                                                            : jfc_pkg::MARKER_PREFIX)) begin
          nxt.verdict = 1'b0;
        end
      end
      jfc_pkg::PH_FILL: begin
        if (data_byte == jfc_pkg::MARKER_PREFIX) begin
          nxt.verdict = cur.verdict;
        end else if (data_byte inside {jfc_pkg::MARKER_EOI, jfc_pkg::MARKER_SOS}) begin
          nxt.verdict = 1'b0;
        end else if (!(data_byte inside {jfc_pkg::MARKER_TEM,
                                         [jfc_pkg::MARKER_RST0:jfc_pkg::MARKER_RST7]})) begin
          nxt.frame_segment = (data_byte == jfc_pkg::MARKER_SOF0);
          nxt.sampling_ok   = 1'b1;
        end
      end
      jfc_pkg::PH_LENHI: begin
        nxt.segment_length = {data_byte, 8'h00};
      end
      jfc_pkg::PH_LENLO: begin
        nxt.segment_length = full_len;
        nxt.byte_position  = jfc_pkg::POS_BODY_START;
        if (len_bad) begin
          nxt.verdict = 1'b0;
        end
      end
      jfc_pkg::PH_BODY: begin
        nxt.sampling_ok   = samp_ok_upd;
        nxt.byte_position = pos_inc;
        if (body_done && cur.frame_segment) begin
          nxt.verdict = samp_ok_upd;
        end
      end
      default: begin
        nxt.verdict = cur.verdict;
      end
    endcase
  end

endmodule

[design/jfc_out_buf.sv]
// Two-entry result buffer: output register plus skid slot.
module jfc_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic            push_data,
  output logic            can_push,
  jfc_out_if.source       out_ch
);

  logic main_valid_r;
  logic main_r;
  logic skid_valid_r;
  logic skid_r;
  logic pop;

  assign pop          = main_valid_r && out_ch.ready;
  assign can_push     = !skid_valid_r;
  assign out_ch.valid = main_valid_r;
  assign out_ch.is_444 = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_r       <= skid_r;
        skid_valid_r <= push;
        skid_r       <= push_data;
      end else begin
        main_valid_r <= push;
        main_r       <= push_data;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_r <= 1'b1;
        main_r       <= push_data;
      end else begin
        skid_valid_r <= 1'b1;
        skid_r       <= push_data;
      end
    end
  end

endmodule

[design/jpeg_444_frame_checker.sv]
// Channel  Dir  Payload                      Transaction
// in_ch    in   data_byte[7:0], last_byte    one file byte, file order
// out_ch   out  is_444                       one verdict per file
//
// One byte is taken per cycle while in_ch.ready is high, with no gaps between files.
// A verdict is registered the cycle after its last byte; it shows on out_ch
// at once if the output register is free, else it waits in the skid slot.
// Reset (rst_n low, synchronous) restarts the walker and empties both slots.
// in_ch.ready is low while the skid slot is full; it rises the cycle after
// out_ch takes a transaction.
`include "assert_macros.svh"

module jpeg_444_frame_checker (
  input  logic      clk,
  input  logic      rst_n,
  jfc_in_if.sink    in_ch,
  jfc_out_if.source out_ch
);

  jfc_pkg::parse_state_t state_r;
  jfc_pkg::parse_state_t state_nxt;
  jfc_pkg::parse_state_t step_nxt;

  logic in_acc;
  logic can_push;
  logic file_end;
  logic result_444;

  assign in_ch.ready = can_push;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign file_end    = in_acc && in_ch.last_byte;

  // walker next state for the incoming byte
  jfc_step u_step (
    .cur       (state_r),
    .data_byte (in_ch.data_byte),
    .nxt       (step_nxt)
  );

  // verdict counts only once decided; undecided files give 0
  assign result_444 = (step_nxt.phase == jfc_pkg::PH_DONE) && step_nxt.verdict;

  always_comb begin
    state_nxt = state_r;
    if (in_acc) begin
      // the last byte restarts the walker for the next file
      state_nxt = in_ch.last_byte ? jfc_pkg::PARSE_RESET : step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jfc_pkg::PARSE_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  jfc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (file_end),
    .push_data (result_444),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

  // input stalls only behind a pending result
  `JFC_ASSERT_IMPL(a_stall_has_result, !in_ch.ready, out_ch.valid)
  // a finished file shows a verdict next cycle
  `JFC_ASSERT_NEXT(a_verdict_follows, file_end, out_ch.valid)
  // walker restarts after every file
  `JFC_ASSERT_NEXT(a_restart, file_end, state_r.phase == jfc_pkg::PH_START0)
  // a decision holds until the file ends
  `JFC_ASSERT_NEXT(a_done_sticky, (state_r.phase == jfc_pkg::PH_DONE) && !file_end,
                   (state_r.phase == jfc_pkg::PH_DONE) && $stable(state_r.verdict))

endmodule

[test/jfc_verdict_monitor.sv]
`timescale 1ns / 100ps

// Watches both channels, walks the marker segments of each file on its own
// and checks every is_444 verdict against the oldest one still owed.
module jfc_verdict_monitor
  import jfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  jfc_in_if    in_ch,
  jfc_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   verdicts,
  output int   hits
);

  phase_t      ph;
  logic [15:0] pos;
  logic [15:0] seg_len;
  logic        in_sof;
  logic        samp_ok;
  logic        decided;

  bit owed_verdicts[$];
  bit want;
  int err_n     = 0;
  int checked_n = 0;
  int hits_n    = 0;

  task automatic restart_walker();
    ph      = PH_START0;
    pos     = '0;
    seg_len = '0;
    in_sof  = 1'b0;
    samp_ok = 1'b1;
    decided = 1'b0;
  endtask

  task automatic settle(input logic v);
    decided = v;
    ph      = PH_DONE;
  endtask

  task automatic close_if_done();
    if (pos >= seg_len) begin
      if (in_sof) settle(samp_ok);
      else ph = PH_MARK;
    end
  endtask

  task automatic walk_byte(input logic [7:0] b);
    case (ph)
      PH_START0: begin
        if (b == MARKER_PREFIX) ph = PH_START1;
        else settle(1'b0);
      end
      PH_START1: begin
        if (b == MARKER_SOI) ph = PH_MARK;
        else settle(1'b0);
      end
      PH_MARK: begin
        if (b == MARKER_PREFIX) ph = PH_FILL;
        else settle(1'b0);
      end
      PH_FILL: begin
        // further 0xFF bytes are fill and keep the walker here
        if (b != MARKER_PREFIX) begin
          if (b == MARKER_EOI || b == MARKER_SOS) begin
            settle(1'b0);
          end else if (b == MARKER_TEM || (b >= MARKER_RST0 && b <= MARKER_RST7)) begin
            ph = PH_MARK;
          end else begin
            in_sof  = (b == MARKER_SOF0);
            samp_ok = 1'b1;
            ph      = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        seg_len = {b, 8'h00};
        ph      = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len = {seg_len[15:8], b};
        pos     = POS_BODY_START;
        if (seg_len < SEG_MIN_LEN || (in_sof && seg_len < SOF0_MIN_LEN)) begin
          settle(1'b0);
        end else begin
          ph = PH_BODY;
          close_if_done();
        end
      end
      PH_BODY: begin
        if (in_sof) begin
          if (pos == POS_NCOMP && b != NCOMP_444) samp_ok = 1'b0;
          if ((pos == POS_SAMP0 || pos == POS_SAMP1 || pos == POS_SAMP2) && b != SAMP_444)
            samp_ok = 1'b0;
        end
        pos = pos + 16'd1;
        close_if_done();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_walker();
      owed_verdicts.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        walk_byte(in_ch.data_byte);
        if (in_ch.last_byte) begin
          owed_verdicts.push_back(ph == PH_DONE && decided);
          restart_walker();
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_verdicts.size() == 0) begin
          $error("is_444: no verdict expected, actual %0b", out_ch.is_444);
          err_n++;
        end else begin
          want = owed_verdicts.pop_front();
          checked_n++;
          if (want) hits_n++;
          if (out_ch.is_444 !== want) begin
            $error("is_444 mismatch: expected %0b, actual %0b", want, out_ch.is_444);
            err_n++;
          end
        end
      end
    end
    errors   <= err_n;
    pending  <= owed_verdicts.size();
    verdicts <= checked_n;
    hits     <= hits_n;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the JPEG 4:4:4 frame checker. Files go in one
// byte per transaction; the monitor predicts and checks each verdict.
module testbench;
  import jfc_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 8;    // verdict is registered the cycle after the last byte

  logic clk;
  logic rst_n;

  jfc_in_if  in_ch();
  jfc_out_if out_ch();

  int mon_errors;
  int mon_pending;
  int mon_verdicts;
  int mon_hits;

  jpeg_444_frame_checker dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  jfc_verdict_monitor u_monitor (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (mon_errors),
    .pending (mon_pending),
    .verdicts(mon_verdicts),
    .hits    (mon_hits)
  );

  // Bytes of the file being built; the last one gets the last_byte flag.
  logic [7:0] file_bytes[$];
  bit         calm;         // no sender gaps for the current file
  bit         hold_req;     // sender asks the receiver for a long hold-off
  int         items_sent;
  int         files_sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One byte per transaction; valid stays high across back-to-back bytes.
  task automatic send_file();
    int gap;
    for (int i = 0; i < file_bytes.size(); i++) begin
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= file_bytes[i];
      in_ch.last_byte <= (i == file_bytes.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      items_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    files_sent++;
  endtask

  // Monitor outputs are registered, so let them update before looking.
  task automatic wait_drained();
    @(posedge clk);
    while (mon_pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, long ready stretches, one long hold-off on
  // request so the result slots fill and the input backs up.
  initial begin : verdict_sink
    int stall;
    int run;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 150) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    int         rand_start;
    int         r;
    int         n_pre;
    int         k;
    bit         cut;
    bit         is_frame;
    bit         hold_done;
    bit         pause_done;
    logic [7:0] code;
    logic [15:0] seg_len;

    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    calm            = 1'b0;
    items_sent      = 0;
    files_sent      = 0;
    hold_done       = 1'b0;
    pause_done      = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed files ----
    // bad first byte
    file_bytes = {8'h00};
    send_file();
    // bad second byte
    file_bytes = {MARKER_PREFIX, MARKER_EOI};
    send_file();
    // non-FF byte where a marker must start
    file_bytes = {MARKER_PREFIX, MARKER_SOI, 8'h12};
    send_file();
    // standalone TEM, fill run, then a scan marker before any frame
    file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_TEM,
                  MARKER_PREFIX, MARKER_PREFIX, MARKER_SOS};
    send_file();
    // segment length below the minimum
    file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, 8'hE0, 8'h00, 8'h01};
    send_file();
    // frame header shorter than its fixed part
    file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_SOF0, 8'h00, 8'h10};
    send_file();

    // ---- random files ----
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      file_bytes.delete();
      if ($urandom_range(0, 99) < 75) begin
        // Marker walk ending in a frame header; mostly well formed, with
        // damaged starts, bad markers, odd lengths and cut-off files mixed in.
        file_bytes.push_back(($urandom_range(0, 99) < 3) ? 8'($urandom) : MARKER_PREFIX);
        file_bytes.push_back(($urandom_range(0, 99) < 3) ? 8'($urandom) : MARKER_SOI);
        n_pre = $urandom_range(0, 3);
        cut   = 1'b0;
        for (int s = 0; s <= n_pre && !cut; s++) begin
          is_frame = (s == n_pre);
          if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3)) file_bytes.push_back(MARKER_PREFIX);
          file_bytes.push_back(($urandom_range(0, 99) < 3) ? 8'($urandom) : MARKER_PREFIX);
          r = $urandom_range(0, 99);
          if (is_frame) begin
            if (r < 2) code = MARKER_EOI;
            else if (r < 4) code = MARKER_SOS;
            else code = MARKER_SOF0;
          end else if (r < 8) begin
            code = MARKER_TEM;
          end else if (r < 20) begin
            code = 8'(MARKER_RST0 + $urandom_range(0, 7));
          end else if (r < 22) begin
            code = MARKER_EOI;
          end else if (r < 24) begin
            code = MARKER_SOS;
          end else if (r < 28) begin
            code = 8'($urandom);
          end else begin
            code = 8'($urandom_range(8'hC1, 8'hFE));
          end
          file_bytes.push_back(code);
          // standalone markers carry no length
          if (code == MARKER_TEM || (code >= MARKER_RST0 && code <= MARKER_RST7)) continue;

          r = $urandom_range(0, 99);
          if (is_frame) begin
            if (r < 8) seg_len = 16'($urandom_range(0, 16));
            else if (r < 70) seg_len = SOF0_MIN_LEN;
            else seg_len = 16'($urandom_range(18, 24));
          end else if (r < 4) begin
            seg_len = 16'($urandom_range(0, 1));
          end else if (r < 9) begin
            seg_len = 16'($urandom_range(65, 65535));
          end else begin
            seg_len = 16'($urandom_range(2, 14));
          end
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);

          if (seg_len > 64) begin
            // long segment: the file ends somewhere inside it
            repeat ($urandom_range(0, 20)) file_bytes.push_back(8'($urandom));
            cut = 1'b1;
          end else begin
            for (int p = 2; p < seg_len; p++) begin
              r = $urandom_range(0, 99);
              if (is_frame && p == POS_NCOMP && r < 85)
                file_bytes.push_back(NCOMP_444);
              else if (is_frame && (p == POS_SAMP0 || p == POS_SAMP1 || p == POS_SAMP2)
                       && r < 90)
                file_bytes.push_back(SAMP_444);
              else
                file_bytes.push_back(8'($urandom));
            end
          end
        end
        // bytes after the frame header are ignored by the walker
        if (!cut) repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 99) < 12) begin
          k = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > k) void'(file_bytes.pop_back());
        end
      end else begin
        // noise, sometimes behind a valid start
        if ($urandom_range(0, 1) != 0) begin
          file_bytes.push_back(MARKER_PREFIX);
          file_bytes.push_back(MARKER_SOI);
          file_bytes.push_back(MARKER_PREFIX);
        end
        repeat ($urandom_range(1, 12))
          file_bytes.push_back(($urandom_range(0, 99) < 30) ? MARKER_PREFIX : 8'($urandom));
      end
      calm = ($urandom_range(0, 99) < 20);
      send_file();

      // Long receiver hold-off while one-byte files keep coming: the
      // result slots fill and the input must stall.
      if (!hold_done && items_sent - rand_start > 600) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        in_ch.valid <= 1'b0;
        while (hold_req) @(posedge clk);
        calm = 1'b1;
        repeat (12) begin
          file_bytes = {8'($urandom)};
          send_file();
        end
      end

      // Sender pause until every owed verdict is back.
      if (!pause_done && items_sent - rand_start > 1200) begin
        pause_done = 1'b1;
        in_ch.valid <= 1'b0;
        wait_drained();
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d files in %0d byte transactions, with fill runs, standalone markers,",
             files_sent, items_sent);
    $display("bad starts and lengths, cut-off files; %0d verdicts checked, %0d of them 4:4:4.",
             mon_verdicts, mon_hits);
    if (mon_errors == 0 && mon_pending == 0) begin
      $display("PASS jpeg_444_frame_checker");
    end else begin
      $display("FAIL jpeg_444_frame_checker");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10000000;
    $display("FAIL jpeg_444_frame_checker");
    $finish;
  end

endmodule
